// ===== design/softmax_log_sum_exp_row_top_defines.svh =====
// Assertion macros shared by the row softmax design
`ifndef SOFTMAX_LOG_SUM_EXP_ROW_TOP_DEFINES_SVH
`define SOFTMAX_LOG_SUM_EXP_ROW_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMX_AST_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMX_AST_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/smx_lse_pkg.sv =====
package smx_lse_pkg;

	localparam logic [31:0] LOG2E_Q22 = 32'd6051102;
	localparam logic [31:0] LN2_Q30   = 32'd744261118;
	localparam logic [31:0] LN2_Q16   = 32'd45426;
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [63:0] Q30_HALF  = 64'h2000_0000;
	localparam logic [63:0] Q23_HALF  = 64'h0080_0000;
	localparam logic [8:0]  EXP_N_MAX = 9'd40;
	localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
	localparam logic signed [15:0] LSE_MAX   = 16'sh7fff;
	localparam logic [3:0]  TAYLOR_TERMS = 4'd8;
	localparam logic [3:0]  SQ_LAST   = 4'd15;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_EX_M0,
		ST_EX_M1,
		ST_EX_U,
		ST_EX_A,
		ST_EX_W,
		ST_EX_Q,
		ST_EX_P,
		ST_EX_R,
		ST_SUM_ACC,
		ST_LN_NORM,
		ST_LN_SQ,
		ST_LN_CHK,
		ST_LN_MUL,
		ST_LN_RES,
		ST_LSE,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMIT_WAIT
	} st_t;

	// reciprocal for floor(w / k), w < 2^30: (w * mult) >> shift
	function automatic logic [30:0] div_mult(input logic [3:0] k);
		logic [30:0] m;
		case (k)
			4'd3:    m = 31'd1431655766;
			4'd5:    m = 31'd1717986919;
			4'd6:    m = 31'd1431655766;
			4'd7:    m = 31'd1227133514;
			default: m = 31'h4000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] div_shift(input logic [3:0] k);
		logic [5:0] s;
		case (k)
			4'd1:    s = 6'd30;
			4'd2:    s = 6'd31;
			4'd3:    s = 6'd32;
			4'd4:    s = 6'd32;
			default: s = 6'd33;
		endcase
		return s;
	endfunction

endpackage

// ===== design/smx_lse_if.sv =====
interface smx_logit_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] logit;

	modport source(output valid, output logit, input ready);
	modport sink(input valid, input logit, output ready);
endinterface

interface smx_result_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  element_index;
	logic        [16:0] probability;
	logic signed [16:0] log_probability;
	logic signed [15:0] row_log_sum_exp;
	logic               last_of_row;

	modport source(output valid, output element_index, output probability,
		output log_probability, output row_log_sum_exp, output last_of_row, input ready);
	modport sink(input valid, input element_index, input probability,
		input log_probability, input row_log_sum_exp, input last_of_row, output ready);
endinterface

// ===== design/softmax_log_sum_exp_row_top.sv =====
// Logits are taken one per cycle while the row fills; the last logit of a row starts processing.
// Each exponential uses one shared 32x32 multiplier: 8 series terms, each through states EX_A, EX_W, EX_Q, EX_P.
// A row of N logits is summed one exponential at a time; the logarithm and log-sum-exp follow,
// then the N results go out through any output stall; no logit is taken until the last beat leaves.
// arst_n clears the fill count, running max, sum and handshakes; row_length resets to 16.
`include "softmax_log_sum_exp_row_top_defines.svh"

module softmax_log_sum_exp_row_top #(
	parameter int MAX_ROW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data,
	smx_logit_if.sink           logit_in,
	smx_result_if.source        res_out
);
	import smx_lse_pkg::*;

	localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int CNT_W = $clog2(MAX_ROW + 1);
	localparam logic [6:0] MAX_LEN = 7'(MAX_ROW);

	st_t state_q, state_d;

	logic        [6:0]       row_len_q;
	logic        [IDX_W-1:0] fill_q;
	logic        [IDX_W-1:0] idx_q;
	logic        [CNT_W-1:0] count_q;
	logic signed [15:0]      max_q;
	logic        [23:0]      sum_q;
	logic                    phase_q;
	logic        [3:0]       k_q;
	logic        [3:0]       sq_cnt_q;
	logic        [4:0]       msb_q;
	logic                    res_valid_q;

	logic        [63:0] prod_q;
	logic        [8:0]  n_q;
	logic        [29:0] u_q;
	logic        [30:0] p_q;
	logic        [29:0] w_q;
	logic        [16:0] exp_q;
	logic        [23:0] norm_q;
	logic        [30:0] m_q;
	logic        [15:0] bits_q;
	logic        [10:0] ln_q;
	logic signed [15:0] lse_q;
	logic        [5:0]  out_idx_q;
	logic        [16:0] out_prob_q;
	logic signed [16:0] out_logp_q;
	logic               out_last_q;

	logic signed [15:0] store_mem [MAX_ROW];
	logic signed [15:0] store_rdata_q;

	logic               in_acc;
	logic               row_end;
	logic        [6:0]  row_len;
	logic [CNT_W-1:0]   fill_cnt;
	logic               store_rd;
	logic        [31:0] mul_a;
	logic        [31:0] mul_b;
	logic signed [16:0] t_diff;
	logic        [15:0] t_val;
	logic        [31:0] sq_val;
	logic        [55:0] round_sum;
	logic signed [16:0] lse_sum;
	logic signed [16:0] logp;
	logic               elem_last;

	assign in_acc   = logit_in.valid & logit_in.ready;
	assign row_len  = (row_len_q == 7'd0) ? 7'd1 : ((row_len_q > MAX_LEN) ? MAX_LEN : row_len_q);
	assign fill_cnt = CNT_W'(fill_q) + CNT_W'(1);
	assign row_end  = (8'(fill_cnt) >= {1'b0, row_len});

	assign t_diff = phase_q ? ({lse_q[15], lse_q} - {store_rdata_q[15], store_rdata_q})
	                        : ({max_q[15], max_q} - {store_rdata_q[15], store_rdata_q});
	assign t_val  = t_diff[15:0];

	assign sq_val    = prod_q[61:30];
	assign round_sum = 56'(p_q) + (56'd1 << (6'd13 + n_q[5:0]));
	assign lse_sum   = {max_q[15], max_q} + $signed({6'd0, ln_q});
	assign logp      = {store_rdata_q[15], store_rdata_q} - {lse_q[15], lse_q};
	assign elem_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign store_rd  = (state_q == ST_SUM_RD) || (state_q == ST_EMIT_RD);

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && row_end) state_d = ST_SUM_RD;
			end
			ST_SUM_RD:  state_d = ST_EX_M0;
			ST_EX_M0: begin
				mul_a   = 32'(t_val);
				mul_b   = LOG2E_Q22;
				state_d = ST_EX_M1;
			end
			ST_EX_M1: begin
				mul_a   = 32'(prod_q[29:0]);
				mul_b   = LN2_Q30;
				state_d = ST_EX_U;
			end
			ST_EX_U:    state_d = ST_EX_A;
			ST_EX_A: begin
				mul_a   = 32'(u_q);
				mul_b   = 32'(p_q);
				state_d = ST_EX_W;
			end
			ST_EX_W:    state_d = ST_EX_Q;
			ST_EX_Q: begin
				mul_a   = 32'(w_q);
				mul_b   = 32'(div_mult(k_q));
				state_d = ST_EX_P;
			end
			ST_EX_P:    state_d = (k_q == 4'd1) ? ST_EX_R : ST_EX_A;
			ST_EX_R:    state_d = phase_q ? ST_EMIT_OUT : ST_SUM_ACC;
			ST_SUM_ACC: state_d = elem_last ? ST_LN_NORM : ST_SUM_RD;
			ST_LN_NORM: begin
				if (sum_q[23:16] == 8'd0) begin
					state_d = ST_LSE;
				end else if (norm_q[23]) begin
					state_d = ST_LN_SQ;
				end
			end
			ST_LN_SQ: begin
				mul_a   = 32'(m_q);
				mul_b   = 32'(m_q);
				state_d = ST_LN_CHK;
			end
			ST_LN_CHK:  state_d = (sq_cnt_q == SQ_LAST) ? ST_LN_MUL : ST_LN_SQ;
			ST_LN_MUL: begin
				mul_a   = 32'({3'(msb_q - 5'd16), bits_q});
				mul_b   = LN2_Q16;
				state_d = ST_LN_RES;
			end
			ST_LN_RES:  state_d = ST_LSE;
			ST_LSE:     state_d = ST_EMIT_RD;
			ST_EMIT_RD: state_d = ST_EX_M0;
			ST_EMIT_OUT: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: begin
				if (res_out.ready) state_d = elem_last ? ST_IDLE : ST_EMIT_RD;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q   <= 7'd16;
			fill_q      <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			max_q       <= LOGIT_MIN;
			sum_q       <= '0;
			phase_q     <= 1'b0;
			k_q         <= '0;
			sq_cnt_q    <= '0;
			msb_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) row_len_q <= cfg_wr_data;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (logit_in.logit > max_q) max_q <= logit_in.logit;
						if (row_end) begin
							count_q <= fill_cnt;
							idx_q   <= '0;
							phase_q <= 1'b0;
							sum_q   <= '0;
						end else begin
							fill_q <= fill_q + IDX_W'(1);
						end
					end
				end
				ST_EX_U:    k_q <= TAYLOR_TERMS;
				ST_EX_P:    k_q <= k_q - 4'd1;
				ST_SUM_ACC: begin
					sum_q <= sum_q + 24'(exp_q);
					msb_q <= 5'd23;
					if (!elem_last) idx_q <= idx_q + IDX_W'(1);
				end
				ST_LN_NORM: begin
					sq_cnt_q <= '0;
					if (!norm_q[23]) msb_q <= msb_q - 5'd1;
				end
				ST_LN_CHK:  sq_cnt_q <= sq_cnt_q + 4'd1;
				ST_LSE: begin
					idx_q   <= '0;
					phase_q <= 1'b1;
				end
				ST_EMIT_OUT: res_valid_q <= 1'b1;
				ST_EMIT_WAIT: begin
					if (res_out.ready) begin
						res_valid_q <= 1'b0;
						if (elem_last) begin
							// close the row
							fill_q  <= '0;
							max_q   <= LOGIT_MIN;
							sum_q   <= '0;
							phase_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_EX_M1: n_q <= prod_q[38:30];
			ST_EX_U: begin
				u_q <= 30'((prod_q + Q30_HALF) >> 30);
				p_q <= Q30_ONE;
			end
			ST_EX_W:  w_q <= 30'((prod_q + (64'(k_q) << 29)) >> 30);
			ST_EX_P:  p_q <= Q30_ONE - 31'(prod_q >> div_shift(k_q));
			ST_EX_R:  exp_q <= (n_q > EXP_N_MAX) ? 17'd0 : 17'(round_sum >> (6'd14 + n_q[5:0]));
			ST_SUM_ACC: norm_q <= sum_q + 24'(exp_q);
			ST_LN_NORM: begin
				if (sum_q[23:16] == 8'd0) begin
					ln_q <= '0;
				end else if (norm_q[23]) begin
					m_q    <= {norm_q, 7'd0};
					bits_q <= '0;
				end else begin
					norm_q <= {norm_q[22:0], 1'b0};
				end
			end
			ST_LN_CHK: begin
				bits_q <= {bits_q[14:0], sq_val[31]};
				m_q    <= sq_val[31] ? sq_val[31:1] : sq_val[30:0];
			end
			ST_LN_RES: ln_q <= 11'((prod_q + Q23_HALF) >> 24);
			ST_LSE:    lse_q <= (!lse_sum[16] && lse_sum[15]) ? LSE_MAX : lse_sum[15:0];
			ST_EMIT_OUT: begin
				out_idx_q  <= 6'(idx_q);
				out_prob_q <= exp_q;
				out_logp_q <= logp;
				out_last_q <= elem_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) store_mem[fill_q] <= logit_in.logit;
		if (store_rd) store_rdata_q <= store_mem[idx_q];
	end

	assign logit_in.ready          = (state_q == ST_IDLE);
	assign res_out.valid           = res_valid_q;
	assign res_out.element_index   = out_idx_q;
	assign res_out.probability     = out_prob_q;
	assign res_out.log_probability = out_logp_q;
	assign res_out.row_log_sum_exp = lse_q;
	assign res_out.last_of_row     = out_last_q;

	`SMX_AST_NXT(a_row_close, res_out.valid && res_out.ready && res_out.last_of_row, state_q == ST_IDLE, "row not closed after last beat")
	`SMX_AST_NXT(a_row_start, in_acc && row_end, state_q == ST_SUM_RD, "full row did not start summing")
	`SMX_AST_IMP(a_prob_range, res_out.valid, res_out.probability <= 17'd65536, "probability above one")
	`SMX_AST_IMP(a_logp_sign, res_out.valid, res_out.log_probability[16] || (res_out.log_probability == 17'sd0), "positive log probability")
	`SMX_AST_IMP(a_lse_ge_max, state_q == ST_EMIT_OUT, lse_q >= max_q, "log-sum-exp below row max")

endmodule

// ===== dv/softmax_log_sum_exp_row_top_tb.sv =====
`timescale 1ns / 100ps

module softmax_log_sum_exp_row_top_tb;

	localparam int MAX_ROW     = 16;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE      = 80;

	typedef struct packed {
		logic        [5:0]  element_index;
		logic        [16:0] probability;
		logic signed [16:0] log_probability;
		logic signed [15:0] row_log_sum_exp;
		logic               last_of_row;
	} softmax_beat_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;

	smx_logit_if  logit_ch();
	smx_result_if res_ch();

	softmax_log_sum_exp_row_top #(
		.MAX_ROW(MAX_ROW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.logit_in(logit_ch),
		.res_out(res_ch)
	);

	// predictor state
	int            row_vals[MAX_ROW];
	int unsigned   row_fill;
	int            row_max;
	logic [6:0]    row_len_reg;
	softmax_beat_t softmax_q[$];
	int            err_count;
	int            idle_cycles;
	int            random_sent;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// round(65536 * e^(-t/256)) by the same fixed-point series as the hardware
	function automatic int unsigned exp_neg_q16(input int unsigned t);
		logic [63:0] y, n, f, u, p;
		int unsigned sh;
		y = 64'(t) * 64'd6051102;
		n = y >> 30;
		f = y & 64'h3FFF_FFFF;
		u = (f * 64'd744261118 + 64'h2000_0000) >> 30;
		p = 64'h4000_0000;
		for (int k = 8; k >= 1; k--)
			p = 64'h4000_0000 - (u * p + 64'(k) * 64'h2000_0000) / (64'(k) * 64'h4000_0000);
		if (n > 40)
			return 0;
		sh = 14 + int'(n);
		return int'((p + (64'd1 << (sh - 1))) >> sh);
	endfunction

	function automatic int unsigned ln_q88(input int unsigned total);
		int unsigned msb;
		logic [63:0] m, bits, l;
		msb = 0;
		bits = 0;
		if (total < 65536)
			return 0;
		for (int i = 0; i < 32; i++)
			if (total[i])
				msb = i;
		m = 64'(total) << (30 - msb);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			bits = bits << 1;
			if (m >= 64'h8000_0000) begin
				bits = bits | 64'd1;
				m = m >> 1;
			end
		end
		l = (64'(msb - 16) << 16) + bits;
		return int'((l * 64'd45426 + (64'd1 << 23)) >> 24);
	endfunction

	task automatic predict_row(input logic signed [15:0] logit);
		int unsigned len, count, total;
		int lse, lp;
		softmax_beat_t b;
		len = row_len_reg;
		if (len == 0)
			len = 1;
		if (len > MAX_ROW)
			len = MAX_ROW;
		if (row_fill < MAX_ROW)
			row_vals[row_fill] = logit;
		if (logit > row_max)
			row_max = logit;
		count = row_fill + 1;
		if (count < len) begin
			row_fill = count;
			return;
		end
		if (count > MAX_ROW)
			count = MAX_ROW;
		total = 0;
		for (int k = 0; k < count; k++)
			total += exp_neg_q16(row_max - row_vals[k]);
		total &= 32'hFF_FFFF;
		lse = row_max + int'(ln_q88(total));
		if (lse > 32767)
			lse = 32767;
		for (int k = 0; k < count; k++) begin
			lp = row_vals[k] - lse;
			b.element_index   = 6'(k);
			b.probability     = 17'(exp_neg_q16(-lp));
			b.log_probability = 17'(lp);
			b.row_log_sum_exp = 16'(lse);
			b.last_of_row     = (k + 1 == count);
			softmax_q.push_back(b);
		end
		row_fill = 0;
		row_max = -32768;
	endtask

	task automatic send_logit(input logic signed [15:0] logit);
		@(negedge clk);
		// burst gap: sometimes drop valid before presenting the logit
		if ($urandom_range(0, 5) == 0) begin
			logit_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		logit_ch.valid <= 1'b1;
		logit_ch.logit <= logit;
		do @(posedge clk); while (!logit_ch.ready);
		predict_row(logit);
	endtask

	task automatic drain();
		@(negedge clk);
		logit_ch.valid <= 1'b0;
		while (softmax_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_row_length(input logic [6:0] len);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		row_len_reg = len;
	endtask

	task automatic test_default_row();
		send_logit(16'sh8000);
		send_logit(16'sh7fff);
		send_logit(16'sh0000);
		send_logit(16'shffff);
		send_logit(16'sh0001);
		for (int i = 5; i < 16; i++)
			send_logit(16'(i * 64 - 256));
		drain();
	endtask

	task automatic test_length_extremes();
		write_row_length(7'd1);
		send_logit(16'sh1234);
		send_logit(16'sh8000);
		drain();
		// zero acts as one
		write_row_length(7'd0);
		send_logit(16'sh7fff);
		drain();
		// above depth clamps to the store size
		write_row_length(7'd127);
		for (int i = 0; i < 16; i++)
			send_logit(16'($urandom));
		drain();
	endtask

	task automatic test_shrink_mid_row();
		write_row_length(7'd16);
		for (int i = 0; i < 5; i++)
			send_logit(16'($urandom_range(0, 1023) - 512));
		drain();
		write_row_length(7'd3);
		send_logit(16'sh0100);
		drain();
	endtask

	task automatic test_saturated_lse();
		write_row_length(7'd4);
		repeat (4) send_logit(16'sh7fff);
		send_logit(16'sh7fff);
		send_logit(16'sh8000);
		send_logit(16'sh7f00);
		send_logit(16'sh8000);
		drain();
	endtask

	task automatic test_random_rows();
		int len, base, spread;
		while (random_sent < 220) begin
			if ($urandom_range(0, 3) != 0) begin
				len = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8);
				write_row_length(7'(len));
			end else begin
				len = (row_len_reg == 0) ? 1 : (row_len_reg > MAX_ROW ? MAX_ROW : row_len_reg);
			end
			base   = $urandom_range(0, 65535) - 32768;
			spread = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 2048);
			for (int i = 0; i < len; i++) begin
				if (spread == 65535)
					send_logit(16'($urandom));
				else
					send_logit(16'(base + $urandom_range(0, spread)));
				random_sent++;
			end
			drain();
		end
	endtask

	// receiver stall pattern: switch between always-ready and random stalls
	int stall_phase;
	logic stall_mode;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_phase  <= 0;
			stall_mode   <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_mode  <= $urandom_range(0, 1);
				stall_phase <= $urandom_range(20, 120);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			res_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		softmax_beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (softmax_q.size() == 0) begin
				$error("unexpected result beat, element_index %0d", res_ch.element_index);
				err_count++;
			end else begin
				want = softmax_q.pop_front();
				if (res_ch.element_index !== want.element_index) begin
					$error("element_index: expected %0d, actual %0d",
						want.element_index, res_ch.element_index);
					err_count++;
				end
				if (res_ch.probability !== want.probability) begin
					$error("probability: expected %0d, actual %0d",
						want.probability, res_ch.probability);
					err_count++;
				end
				if (res_ch.log_probability !== want.log_probability) begin
					$error("log_probability: expected %0d, actual %0d",
						want.log_probability, res_ch.log_probability);
					err_count++;
				end
				if (res_ch.row_log_sum_exp !== want.row_log_sum_exp) begin
					$error("row_log_sum_exp: expected %0d, actual %0d",
						want.row_log_sum_exp, res_ch.row_log_sum_exp);
					err_count++;
				end
				if (res_ch.last_of_row !== want.last_of_row) begin
					$error("last_of_row: expected %0d, actual %0d",
						want.last_of_row, res_ch.last_of_row);
					err_count++;
				end
			end
		end
	end

	// count cycles with work pending but no beat moving
	always @(posedge clk) begin
		if ((logit_ch.valid && logit_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else if (logit_ch.valid || softmax_q.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("softmax_log_sum_exp_row_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		logit_ch.valid = 1'b0;
		logit_ch.logit = '0;
		err_count      = 0;
		idle_cycles    = 0;
		random_sent    = 0;
		row_fill       = 0;
		row_max        = -32768;
		row_len_reg    = 7'd16;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		test_default_row();
		test_length_extremes();
		test_shrink_mid_row();
		test_saturated_lse();
		test_random_rows();
		drain();

		if (err_count == 0)
			$display("softmax_log_sum_exp_row_top verification clean");
		else
			$display("softmax_log_sum_exp_row_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/smx_lse_pkg.sv
design/smx_lse_if.sv
design/softmax_log_sum_exp_row_top.sv
dv/softmax_log_sum_exp_row_top_tb.sv
